@@ sv/tkvs_pkg.sv @@
// ----------------------------------------------------------------------------
// tkvs_pkg
// Shared types and constants for the top-k vector similarity search block.
// ----------------------------------------------------------------------------
package tkvs_pkg;

  localparam int MaxWords    = 1024;
  localparam int MaxPlanes   = 64;
  localparam int MaxResults  = 16;
  localparam int WordW       = $clog2(MaxWords);
  localparam int PlaneW      = $clog2(MaxPlanes);
  localparam int AddrW       = WordW + PlaneW;
  localparam int KeepDepth   = MaxResults + 1;
  localparam int KeepW       = $clog2(KeepDepth + 1);
  localparam int ScoreW      = 36;
  localparam int AccW        = 40;
  localparam int CfgW        = 11;
  localparam int CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] RegPlanes = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWords  = 1'b1;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic signed [ScoreW-1:0] ScoreLimit = 36'sd17179869184;

  typedef struct packed {
    logic             command;
    logic [9:0]       word_index;
    logic [5:0]       plane_index;
    logic signed [15:0] element_value;
    logic [4:0]       result_count;
  } req_t;

  typedef struct packed {
    logic [9:0]               similar_word;
    logic [3:0]               rank;
    logic signed [ScoreW-1:0] score;
    logic                     last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                     start;
    logic                     valid;
    logic signed [ScoreW-1:0] score;
    logic [WordW-1:0]         index;
  } ins_t;

endpackage

@@ sv/tkvs_if.sv @@
// ----------------------------------------------------------------------------
// tkvs_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tkvs_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/top_k_vector_similarity_search_top.sv @@
// Write: accepted every cycle, back to back, while idle. Query: for each row in
// use, a MAC pass over the planes, an insertion if the row enters the best list,
// then kept entries emitted with receiver stalls; one item at a time.
// Throughput set by the single MAC unit and one vector memory read per cycle.
// Reset (rst, synchronous): control clears, registers go to 64 planes and
// 1024 words; the vector memory is undefined until written.
// ----------------------------------------------------------------------------
// top_k_vector_similarity_search_top
// Vector table, shared MAC sequencer and top-k ranking.
// ----------------------------------------------------------------------------
module top_k_vector_similarity_search_top
  import tkvs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  tkvs_if.sink            req,
  tkvs_if.source          rsp
);

  logic [6:0]  planes_in_use;
  logic [10:0] words_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes_in_use <= 7'd64;
      words_in_use  <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPlanes: planes_in_use <= cfg_data[6:0];
        RegWords:  words_in_use  <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic signed [15:0] mem [MaxWords*MaxPlanes];
  logic signed [15:0] rdata;
  logic [AddrW-1:0]   raddr;
  logic               mem_we;
  logic [AddrW-1:0]   waddr;
  logic signed [15:0] wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t state, state_next;
  req_t   cur;
  logic [WordW:0]      nw;
  logic [6:0]          np;
  logic [4:0]          cnt;
  logic [WordW:0]      row;
  logic [6:0]          plane;
  logic                phase;
  logic signed [15:0]  qval;
  logic signed [AccW-1:0] acc;
  logic signed [31:0]  prod;
  logic                prod_v;
  logic                read_v;
  logic                mac_done;
  logic [KeepW-1:0]    rd_pos;
  logic [4:0]          n_out;
  logic                out_v;
  rsp_t                out_r;
  ins_t                ins;
  logic                tk_busy;
  logic [KeepW-1:0]    filled;
  logic signed [ScoreW-1:0] rd_score;
  logic [WordW-1:0]    rd_index;
  logic                emit_step;
  logic                emit_fire;

  logic [WordW:0] nw_c;
  logic [6:0]     np_c;
  logic [4:0]     cnt_c;
  always_comb begin
    nw_c = words_in_use > 11'(MaxWords) ? (WordW+1)'(MaxWords) :
           (words_in_use < 11'd2 ? (WordW+1)'(2) : words_in_use[WordW:0]);
    np_c = planes_in_use > 7'(MaxPlanes) ? 7'(MaxPlanes) : planes_in_use;
    cnt_c = req.data.result_count > 5'(MaxResults) ? 5'(MaxResults)
          : req.data.result_count;
    if ({6'd0, cnt_c} > nw_c - 1'b1) cnt_c = 5'(nw_c - 1'b1);
  end

  assign req.ready = (state == ST_IDLE);
  wire take = req.valid && req.ready;

  tkvs_topk u_topk (
    .clk(clk), .rst(rst), .ins(ins), .keep(KeepW'(cnt) + 1'b1), .rd_pos(rd_pos),
    .busy(tk_busy), .filled(filled), .rd_score(rd_score), .rd_index(rd_index)
  );

  assign emit_step = (state == ST_EMIT) && (!out_v || (rsp.valid && rsp.ready))
                     && rd_pos != filled && n_out != cnt;
  assign emit_fire = emit_step && (rd_index != cur.word_index);

  logic signed [AccW-1:0] sat_in;
  logic signed [ScoreW-1:0] sat;
  always_comb begin
    sat_in = acc + AccW'(prod);
    if (!prod_v) sat_in = acc;
    if (sat_in > AccW'(ScoreLimit)) sat = ScoreLimit;
    else if (sat_in < -AccW'(ScoreLimit)) sat = -ScoreLimit;
    else sat = sat_in[ScoreW-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (take && req.data.command == CmdQuery && {1'b0, req.data.word_index} < nw_c
            && cnt_c != '0)
          state_next = ST_READ;
      ST_READ:   state_next = ST_MAC;
      ST_MAC:    if (mac_done) state_next = ST_INSERT;
      ST_INSERT: if (!tk_busy && !ins.valid) begin
        if (row == nw) state_next = ST_EMIT;
        else state_next = ST_READ;
      end
      ST_EMIT:   if ((rd_pos == filled || n_out == cnt) && !out_v) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = take && req.data.command == CmdWrite;
    waddr  = {req.data.word_index, req.data.plane_index};
    wdata  = req.data.element_value;
    raddr  = {cur.word_index, plane[PlaneW-1:0]};
    if (phase) raddr = {row[WordW-1:0], plane[PlaneW-1:0]};
  end

  assign mac_done = (plane == np) && !phase && !read_v && !prod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      out_v  <= 1'b0;
      ins    <= '0;
      prod_v <= 1'b0;
      read_v <= 1'b0;
      cnt    <= '0;
    end else begin
      state     <= state_next;
      ins.start <= take;
      ins.valid <= (state == ST_MAC) && mac_done;
      out_v     <= emit_fire || (out_v && !(rsp.valid && rsp.ready));
      case (state)
        ST_IDLE: if (take) begin
          cur   <= req.data;
          nw    <= nw_c;
          np    <= np_c;
          cnt   <= cnt_c;
          row   <= '0;
        end
        ST_READ: begin
          plane  <= '0;
          phase  <= 1'b0;
          acc    <= '0;
          prod_v <= 1'b0;
          read_v <= 1'b0;
        end
        ST_MAC: begin
          // alternate reads: query element, then row element
          if (prod_v) acc <= acc + AccW'(prod);
          if (read_v && !phase) prod <= qval * rdata;
          if (read_v && phase) qval <= rdata;
          prod_v <= read_v && !phase;
          read_v <= (plane != np);
          if (plane != np) begin
            phase  <= !phase;
            if (phase) plane <= plane + 1'b1;
          end else if (phase) begin
            phase <= 1'b0;
          end
          if (mac_done) begin
            ins.score <= sat;
            ins.index <= row[WordW-1:0];
            row       <= row + 1'b1;
            rd_pos    <= '0;
            n_out     <= '0;
          end
        end
        ST_EMIT: if (emit_step) begin
          rd_pos <= rd_pos + 1'b1;
          if (emit_fire) begin
            out_r.similar_word <= rd_index;
            out_r.rank  <= n_out[3:0];
            out_r.score <= rd_score;
            out_r.last  <= (n_out == cnt - 1'b1);
            n_out <= n_out + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid = out_v;
  assign rsp.data  = out_r;

`ifndef SYNTH
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !req.ready) else $error("ready while busy");
  a_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.last |-> rsp.data.rank == 4'(cnt - 1'b1)) else $error("bad last");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == ST_EMIT || state == ST_IDLE) else $error("stray result");
`endif

endmodule

@@ sv/tkvs_topk.sv @@
// ----------------------------------------------------------------------------
// tkvs_topk
// Sorted best list; one compare-and-shift step per cycle per insertion.
// ----------------------------------------------------------------------------
module tkvs_topk
  import tkvs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ins_t                     ins,
  input  logic [KeepW-1:0]         keep,
  input  logic [KeepW-1:0]         rd_pos,
  output logic                     busy,
  output logic [KeepW-1:0]         filled,
  output logic signed [ScoreW-1:0] rd_score,
  output logic [WordW-1:0]         rd_index
);

  logic signed [ScoreW-1:0] scores  [KeepDepth];
  logic [WordW-1:0]         indices [KeepDepth];
  logic [KeepW-1:0]         pos;
  logic signed [ScoreW-1:0] cur_score;
  logic [WordW-1:0]         cur_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      filled <= '0;
      pos    <= '0;
    end else if (ins.start) begin
      filled <= '0;
      busy   <= 1'b0;
    end else if (!busy && ins.valid) begin
      cur_score <= ins.score;
      cur_index <= ins.index;
      if (filled < keep) begin
        pos    <= filled;
        filled <= filled + 1'b1;
        busy   <= 1'b1;
      end else if (ins.score > scores[keep - 1'b1]) begin
        pos  <= keep - 1'b1;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (pos != '0 && cur_score > scores[pos - 1'b1]) begin
        scores[pos]  <= scores[pos - 1'b1];
        indices[pos] <= indices[pos - 1'b1];
        pos          <= pos - 1'b1;
      end else begin
        scores[pos]  <= cur_score;
        indices[pos] <= cur_index;
        busy         <= 1'b0;
      end
    end
  end

  assign rd_score = scores[rd_pos];
  assign rd_index = indices[rd_pos];

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= keep || ins.start || $past(ins.start)) else $error("fill beyond keep");
  a_ins_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ins.valid) else $error("insert while busy");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos < KeepDepth) else $error("position out of range");
`endif

endmodule

@@ tb/sv/tkvs_checker.sv @@
// ----------------------------------------------------------------------------
// tkvs_checker
// Watches the configuration port and both channels, keeps a shadow vector
// table and register set, ranks each query and compares every result transfer
// against the oldest predicted hit.
// ----------------------------------------------------------------------------
module tkvs_checker
  import tkvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               req_valid,
  input  logic               req_ready,
  input  req_t               req_data,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  rsp_t               rsp_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatLimit = 64'sd17179869184;

  logic signed [15:0] vec_mem [MaxWords*MaxPlanes];
  logic [6:0]         planes_reg;
  logic [10:0]        words_reg;
  rsp_t               hits_q[$];

  function automatic longint row_score(int a, int b, int np);
    longint acc;
    acc = 0;
    for (int p = 0; p < np; p++)
      acc += longint'(vec_mem[a*MaxPlanes+p]) * longint'(vec_mem[b*MaxPlanes+p]);
    if (acc > SatLimit) acc = SatLimit;
    if (acc < -SatLimit) acc = -SatLimit;
    return acc;
  endfunction

  task automatic rank_query(req_t q);
    int     nw, np, cnt, keep, filled, pos, n, w;
    longint s;
    longint bs [KeepDepth];
    int     bi [KeepDepth];
    rsp_t   hit;
    nw = words_reg;
    if (nw > MaxWords) nw = MaxWords;
    if (nw < 2) nw = 2;
    np = planes_reg;
    if (np > MaxPlanes) np = MaxPlanes;
    w = q.word_index;
    if (w >= nw) return;
    cnt = q.result_count;
    if (cnt > MaxResults) cnt = MaxResults;
    if (cnt > nw - 1) cnt = nw - 1;
    if (cnt == 0) return;
    keep = cnt + 1;
    filled = 0;
    for (int r = 0; r < nw; r++) begin
      s = row_score(w, r, np);
      if (filled < keep) begin
        pos = filled;
        filled++;
      end else if (s > bs[keep-1]) begin
        pos = keep - 1;
      end else begin
        continue;
      end
      while (pos > 0 && s > bs[pos-1]) begin
        bs[pos] = bs[pos-1];
        bi[pos] = bi[pos-1];
        pos--;
      end
      bs[pos] = s;
      bi[pos] = r;
    end
    n = 0;
    for (int i = 0; i < filled && n < cnt; i++) begin
      if (bi[i] == w) continue;
      hit.similar_word = bi[i][9:0];
      hit.rank         = n[3:0];
      hit.score        = bs[i][ScoreW-1:0];
      hit.last         = (n == cnt - 1);
      hits_q = {hits_q, hit};
      n++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_hit;
    if (rst) begin
      planes_reg = 7'd64;
      words_reg  = 11'd1024;
      errors     = 0;
      hits_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegPlanes) planes_reg = cfg_data[6:0];
        else words_reg = cfg_data;
      end
      if (req_valid && req_ready) begin
        if (req_data.command == CmdWrite)
          vec_mem[{req_data.word_index, req_data.plane_index}] = req_data.element_value;
        else
          rank_query(req_data);
      end
      if (rsp_valid && rsp_ready) begin
        if (hits_q.size() == 0) begin
          $error("unexpected result transfer: word %0d rank %0d",
                 rsp_data.similar_word, rsp_data.rank);
          errors++;
        end else begin
          exp_hit = hits_q.pop_front();
          if (rsp_data.similar_word !== exp_hit.similar_word) begin
            $error("similar_word: expected %0d, got %0d",
                   exp_hit.similar_word, rsp_data.similar_word);
            errors++;
          end
          if (rsp_data.rank !== exp_hit.rank) begin
            $error("rank: expected %0d, got %0d", exp_hit.rank, rsp_data.rank);
            errors++;
          end
          if (rsp_data.score !== exp_hit.score) begin
            $error("score: expected %0d, got %0d", exp_hit.score, rsp_data.score);
            errors++;
          end
          if (rsp_data.last !== exp_hit.last) begin
            $error("last: expected %0d, got %0d", exp_hit.last, rsp_data.last);
            errors++;
          end
        end
      end
    end
    pending = hits_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Loads vector table regions under several plane/row settings, runs directed
// and random similarity queries with varying handshake idling and back
// pressure, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import tkvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 200000;
  localparam int HoldCycles = 3000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  tkvs_if #(.T(req_t)) req_ch ();
  tkvs_if #(.T(rsp_t)) rsp_ch ();

  int   errors, pending;
  int   tx_pct, rx_pct;
  int   eff_np, eff_nw;
  int   n_wr, n_qry;
  int   idle_cyc = 0;
  logic want_hold, hold_done;

  always #5 clk = ~clk;

  top_k_vector_similarity_search_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
  );

  tkvs_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .errors(errors), .pending(pending)
  );

  // receiver: random ready, one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
  end

  initial begin
    wait (idle_cyc >= IdleLimit);
    $display("watchdog: no transfer for %0d cycles", IdleLimit);
    $display("** top_k_vector_similarity_search_top: FAILED **");
    $finish;
  end

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t mk_write(int w, int p, logic [15:0] v);
    req_t t;
    t.command       = CmdWrite;
    t.word_index    = w[9:0];
    t.plane_index   = p[5:0];
    t.element_value = v;
    t.result_count  = 5'($urandom);
    return t;
  endfunction

  function automatic req_t mk_query(int w, int c);
    req_t t;
    t.command       = CmdQuery;
    t.word_index    = w[9:0];
    t.plane_index   = 6'($urandom);
    t.element_value = 16'($urandom);
    t.result_count  = c[4:0];
    return t;
  endfunction

  task automatic send(req_t t);
    while ($urandom_range(99) < tx_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (t.command == CmdWrite) n_wr++;
    else n_qry++;
  endtask

  // wait for every result, then for the block to go idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (2) @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_regs(int planes, int words);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= RegPlanes;
    cfg_data  <= CfgW'(planes);
    @(posedge clk);
    cfg_index <= RegWords;
    cfg_data  <= CfgW'(words);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_np = (planes > MaxPlanes) ? MaxPlanes : planes;
    eff_nw = (words > MaxWords) ? MaxWords : ((words < 2) ? 2 : words);
  endtask

  // pattern 0: random, 1: overflow rows, 2: fixed mix with rows 1 and 4 equal
  task automatic fill(int pattern);
    logic [15:0] v;
    int          rr;
    for (int r = 0; r < eff_nw; r++)
      for (int p = 0; p < eff_np; p++) begin
        case (pattern)
          1: v = (r < 2) ? 16'h8000 : 16'h7fff;
          2: begin
            rr = (r == 4) ? 1 : r;
            case ((rr * 7 + p * 13) % 5)
              0: v = 16'h8000;
              1: v = 16'h7fff;
              2: v = 16'h0000;
              3: v = 16'h3039;
              default: v = 16'hffff;
            endcase
          end
          default: v = rand_elem();
        endcase
        send(mk_write(r, p, v));
      end
  endtask

  task automatic run_random(int n);
    int w, c;
    repeat (n) begin
      if ($urandom_range(9) < 3) begin
        send(mk_write($urandom_range(1023), $urandom_range(63), rand_elem()));
      end else begin
        w = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(eff_nw - 1);
        c = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
        send(mk_query(w, c));
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = RegPlanes;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    want_hold    = 1'b0;
    tx_pct = 12;
    rx_pct = 87;
    eff_np = 64;
    eff_nw = 1024;
    n_wr = 0;
    n_qry = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ties, count saturation, rows out of use
    set_regs(2, 6);
    fill(2);
    send(mk_query(0, 1));
    send(mk_query(1, 5));
    send(mk_query(4, 16));
    send(mk_query(5, 31));
    send(mk_query(2, 0));
    send(mk_query(6, 3));
    send(mk_query(1023, 2));
    // score saturation in both directions
    set_regs(17, 3);
    fill(1);
    send(mk_query(0, 2));
    send(mk_query(2, 2));

    tx_pct = 87;
    rx_pct = 12;
    set_regs(0, 1);
    run_random(6);
    set_regs(0, 2047);
    run_random(5);

    tx_pct = 0;
    rx_pct = 0;
    set_regs(2, 6);
    want_hold = 1'b1;
    run_random(20);
    wait (hold_done);
    want_hold = 1'b0;
    run_random(8);

    drain();
    $display("Covered %0d table writes and %0d queries: ties, score saturation,",
             n_wr, n_qry);
    $display("row and count clamping, three idle patterns and a long result hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("** top_k_vector_similarity_search_top: PASSED **");
    end else begin
      $display("** top_k_vector_similarity_search_top: FAILED **");
    end
    $finish;
  end

endmodule
